FILE: rtl/rgc_pkg.sv
`timescale 1ns / 1ps

package rgc_pkg;

   localparam int DEFAULT_COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH         = 16;
   localparam int GRADE_WIDTH         = 5;
   localparam int RSP_FIELDS_WIDTH    = 3 * FIELD_WIDTH + GRADE_WIDTH;
   localparam int RSP_TDATA_WIDTH     = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
   localparam logic [7:0] CHAR_EXCLAIM  = 8'h21;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;

   // Doubled, scaled numerator: 2*(588L - 2960S - 1580W) + 100W
   localparam int MUL_LETTER   = 1176;
   localparam int MUL_SENTENCE = 5920;
   localparam int MUL_WORD     = 3060;
   // Doubled denominator 200W, pre-shifted by the top quotient bit
   localparam int DIV_SCALE    = 3200;
   localparam int GRADE_TOP    = 16;
   localparam logic [2:0] STEP_TOP = 3'd4;

   typedef struct packed {
      logic idle;
      logic done;
   } grade_status_type;

endpackage

FILE: rtl/rgc_counter.sv
`timescale 1ns / 1ps

module rgc_counter #(
   parameter int COUNT_WIDTH = rgc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   beat,
   input  logic [7:0]             text_byte,
   input  logic                   end_of_text,
   output logic [COUNT_WIDTH-1:0] letters_next,
   output logic [COUNT_WIDTH-1:0] words_next,
   output logic [COUNT_WIDTH-1:0] sentences_next
);

   logic [COUNT_WIDTH-1:0] letters_ff;
   logic [COUNT_WIDTH-1:0] words_ff;
   logic [COUNT_WIDTH-1:0] sentences_ff;
   logic                   is_letter;
   logic                   is_space;
   logic                   is_mark;

   always_comb begin
      is_letter = text_byte inside {[rgc_pkg::CHAR_UPPER_A:rgc_pkg::CHAR_UPPER_Z],
                                    [rgc_pkg::CHAR_LOWER_A:rgc_pkg::CHAR_LOWER_Z]};
      is_space  = text_byte == rgc_pkg::CHAR_SPACE;
      is_mark   = text_byte inside {rgc_pkg::CHAR_PERIOD, rgc_pkg::CHAR_EXCLAIM,
                                    rgc_pkg::CHAR_QUESTION};
   end

   // Counts including the current byte; each holds at all ones
   always_comb begin
      letters_next   = letters_ff;
      words_next     = words_ff;
      sentences_next = sentences_ff;
      if (is_letter && !(&letters_ff)) begin
         letters_next = letters_ff + COUNT_WIDTH'(1);
      end
      if (is_space && !(&words_ff)) begin
         words_next = words_ff + COUNT_WIDTH'(1);
      end
      if (is_mark && !(&sentences_ff)) begin
         sentences_next = sentences_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letters_ff   <= '0;
         words_ff     <= COUNT_WIDTH'(1);
         sentences_ff <= '0;
      end else if (beat) begin
         if (end_of_text) begin
            letters_ff   <= '0;
            words_ff     <= COUNT_WIDTH'(1);
            sentences_ff <= '0;
         end else begin
            letters_ff   <= letters_next;
            words_ff     <= words_next;
            sentences_ff <= sentences_next;
         end
      end
   end

endmodule

FILE: rtl/rgc_grade_unit.sv
`timescale 1ns / 1ps

module rgc_grade_unit #(
   parameter int COUNT_WIDTH = rgc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  out_free,
   input  logic [COUNT_WIDTH-1:0]                letters,
   input  logic [COUNT_WIDTH-1:0]                words,
   input  logic [COUNT_WIDTH-1:0]                sentences,
   output rgc_pkg::grade_status_type             status,
   output logic [COUNT_WIDTH-1:0]                letters_held,
   output logic [COUNT_WIDTH-1:0]                words_held,
   output logic [COUNT_WIDTH-1:0]                sentences_held,
   output logic [rgc_pkg::GRADE_WIDTH-1:0]       grade
);

   localparam int XW = COUNT_WIDTH + 15;
   localparam int DW = COUNT_WIDTH + 12;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SUB_S = 3'd2;
   localparam logic [2:0] ST_SUB_W = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [COUNT_WIDTH-1:0]          l_ff, l_in;
   logic [COUNT_WIDTH-1:0]          w_ff, w_in;
   logic [COUNT_WIDTH-1:0]          s_ff, s_in;
   logic [XW-1:0]                   acc_ff, acc_in;
   logic [DW-1:0]                   d_ff, d_in;
   logic [rgc_pkg::GRADE_WIDTH-1:0] q_ff, q_in;
   logic [2:0]                      step_ff, step_in;

   // Shared add/subtract unit
   logic [XW-1:0] unit_a;
   logic [XW-1:0] unit_b;
   logic          unit_sub;
   logic [XW-1:0] unit_sum;

   always_comb begin
      unit_a   = acc_ff;
      unit_b   = XW'(d_ff);
      unit_sub = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            unit_a   = '0;
            unit_b   = XW'(l_ff) * XW'(rgc_pkg::MUL_LETTER);
            unit_sub = 1'b0;
         end
         ST_SUB_S: unit_b = XW'(s_ff) * XW'(rgc_pkg::MUL_SENTENCE);
         ST_SUB_W: unit_b = XW'(w_ff) * XW'(rgc_pkg::MUL_WORD);
         default:  unit_b = XW'(d_ff);
      endcase
      unit_sum = unit_a + (unit_sub ? ~unit_b : unit_b) + XW'(unit_sub);
   end

   always_comb begin
      state_in = state_ff;
      l_in     = l_ff;
      w_in     = w_ff;
      s_in     = s_ff;
      acc_in   = acc_ff;
      d_in     = d_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               l_in     = letters;
               w_in     = words;
               s_in     = sentences;
               d_in     = DW'(words) * DW'(rgc_pkg::DIV_SCALE);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            acc_in   = unit_sum;
            state_in = ST_SUB_S;
         end
         ST_SUB_S: begin
            acc_in   = unit_sum;
            state_in = ST_SUB_W;
         end
         ST_SUB_W: begin
            acc_in   = unit_sum;
            q_in     = '0;
            step_in  = rgc_pkg::STEP_TOP;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            d_in    = d_ff >> 1;
            step_in = step_ff - 3'd1;
            if (acc_ff[XW-1]) begin
               // negative numerator rounds to zero or below
               q_in     = '0;
               state_in = ST_DONE;
            end else if (!unit_sum[XW-1] && step_ff == rgc_pkg::STEP_TOP) begin
               q_in     = rgc_pkg::GRADE_WIDTH'(rgc_pkg::GRADE_TOP);
               state_in = ST_DONE;
            end else begin
               if (!unit_sum[XW-1]) begin
                  acc_in = unit_sum;
               end
               q_in = {q_ff[rgc_pkg::GRADE_WIDTH-2:0], !unit_sum[XW-1]};
               if (step_ff == 3'd0) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff    <= l_in;
      w_ff    <= w_in;
      s_ff    <= s_in;
      acc_ff  <= acc_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign status.idle    = state_ff == ST_IDLE;
   assign status.done    = state_ff == ST_DONE;
   assign letters_held   = l_ff;
   assign words_held     = w_ff;
   assign sentences_held = s_ff;
   assign grade          = q_ff;

endmodule

FILE: rtl/readability_grade_counter_top.sv
// Coleman-Liau readability counter. Text arrives one byte per req beat, with
// req_tlast on the final byte; ordinary bytes are counted at one per cycle.
// The final byte is counted too and then starts the grade calculation: one
// shared add/subtract unit builds the scaled numerator in three steps and
// runs a restoring division of up to five steps. req_tready stays low after a
// last byte until the grade is passed to the output: sooner when the first
// division step already settles it (negative numerator or grade 16+), later
// while a previous result waits on rsp_tready. Each text yields one rsp beat
// carrying the saturated counts and the grade, rounded half away from zero
// and clamped to 0 through 16.
`timescale 1ns / 1ps

module readability_grade_counter_top #(
   parameter int COUNT_WIDTH = rgc_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // text_byte
   input  logic                                req_tlast,   // end_of_text
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // letter_count, word_count, sentence_count, grade_level, zero pad
   output logic [rgc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   localparam int FW = rgc_pkg::FIELD_WIDTH;
   localparam int GW = rgc_pkg::GRADE_WIDTH;
   localparam int PW = rgc_pkg::RSP_TDATA_WIDTH - rgc_pkg::RSP_FIELDS_WIDTH;

   logic                              beat;
   logic [COUNT_WIDTH-1:0]            letters_next, words_next, sentences_next;
   logic [COUNT_WIDTH-1:0]            letters_held, words_held, sentences_held;
   logic [GW-1:0]                     grade;
   rgc_pkg::grade_status_type         status;
   logic                              out_free;
   logic [FW-1:0]                     letter_field, word_field, sentence_field;
   logic                              rsp_valid_ff;
   logic [rgc_pkg::RSP_TDATA_WIDTH-1:0] rsp_data_ff;

   assign req_tready = status.idle;
   assign beat       = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   rgc_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_counter (
      .clock          (clock),
      .reset          (reset),
      .beat           (beat),
      .text_byte      (req_tdata),
      .end_of_text    (req_tlast),
      .letters_next   (letters_next),
      .words_next     (words_next),
      .sentences_next (sentences_next)
   );

   rgc_grade_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_grade (
      .clock          (clock),
      .reset          (reset),
      .start          (beat && req_tlast),
      .out_free       (out_free),
      .letters        (letters_next),
      .words          (words_next),
      .sentences      (sentences_next),
      .status         (status),
      .letters_held   (letters_held),
      .words_held     (words_held),
      .sentences_held (sentences_held),
      .grade          (grade)
   );

   // Clamp wide counts to the field range
   generate
      if (COUNT_WIDTH > FW) begin : g_sat
         assign letter_field   = (|letters_held[COUNT_WIDTH-1:FW])   ? '1 : letters_held[FW-1:0];
         assign word_field     = (|words_held[COUNT_WIDTH-1:FW])     ? '1 : words_held[FW-1:0];
         assign sentence_field = (|sentences_held[COUNT_WIDTH-1:FW]) ? '1 : sentences_held[FW-1:0];
      end else begin : g_ext
         assign letter_field   = FW'(letters_held);
         assign word_field     = FW'(words_held);
         assign sentence_field = FW'(sentences_held);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.done && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done && out_free) begin
         rsp_data_ff <= {PW'(0), grade, sentence_field, word_field, letter_field};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_last : assert property (@(posedge clock) disable iff (reset)
      beat && req_tlast |=> !req_tready)
      else $error("grade unit did not start on last byte");

   a_grade_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3*FW+GW-1:3*FW] <= GW'(rgc_pkg::GRADE_TOP))
      else $error("grade out of range");

   a_words_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2*FW-1:FW] != '0)
      else $error("word count is zero");

   a_done_loads : assert property (@(posedge clock) disable iff (reset)
      status.done && out_free |=> rsp_tvalid && status.idle)
      else $error("finished grade not moved to output");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int          CLK_HALF        = 5;
   localparam int          RESET_CYCLES    = 8;
   localparam int          CYCLE_LIMIT     = 200_000;
   localparam int          DRAIN_CYCLES    = 40;
   localparam int          BEATS_PER_PHASE = 475;
   localparam int          COUNT_W         = rgc_pkg::DEFAULT_COUNT_WIDTH;
   localparam int          FW              = rgc_pkg::FIELD_WIDTH;
   localparam int          GW              = rgc_pkg::GRADE_WIDTH;
   localparam longint      LETTER_WEIGHT   = 588;
   localparam longint      SENTENCE_WEIGHT = 2960;
   localparam longint      WORD_WEIGHT     = 1580;
   localparam longint      GRADE_SCALE     = 100;
   localparam longint      FIELD_MAX       = 65535;

   // packed from the top down, so letters sits in the lowest bits of rsp_tdata
   typedef struct packed {
      logic [GW-1:0] grade;
      logic [FW-1:0] sentences;
      logic [FW-1:0] words;
      logic [FW-1:0] letters;
   } grade_report_type;

   typedef enum logic [1:0] {CH_LETTER, CH_SPACE, CH_MARK, CH_OTHER} char_kind_type;

   typedef struct {
      logic [7:0]       ch;
      int unsigned      reps;
      bit               last;
      bit               typed;
      grade_report_type want;
   } text_row_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [7:0]                          req_tdata;   // text_byte
   logic                                req_tlast;   // end_of_text
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   // letter_count, word_count, sentence_count, grade_level, zero pad
   logic [rgc_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;

   grade_report_type rsp_report;
   grade_report_type oldest_report;
   grade_report_type pending_reports[$];
   text_row_type     directed_rows[$];

   logic [COUNT_W-1:0] letters_seen;
   logic [COUNT_W-1:0] words_seen;
   logic [COUNT_W-1:0] sentences_seen;

   int          send_idle_pct;
   int          recv_stall_pct;
   int unsigned sent_beats;
   int unsigned mismatches;
   int unsigned cycle_count;

   assign rsp_report = rsp_tdata[rgc_pkg::RSP_FIELDS_WIDTH-1:0];

   readability_grade_counter_top #(
      .COUNT_WIDTH(COUNT_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLK_HALF clock = ~clock;

   function automatic char_kind_type kind_of(input logic [7:0] ch);
      if ((ch >= rgc_pkg::CHAR_UPPER_A && ch <= rgc_pkg::CHAR_UPPER_Z) ||
          (ch >= rgc_pkg::CHAR_LOWER_A && ch <= rgc_pkg::CHAR_LOWER_Z)) begin
         return CH_LETTER;
      end else if (ch == rgc_pkg::CHAR_SPACE) begin
         return CH_SPACE;
      end else if (ch == rgc_pkg::CHAR_PERIOD || ch == rgc_pkg::CHAR_EXCLAIM ||
                   ch == rgc_pkg::CHAR_QUESTION) begin
         return CH_MARK;
      end
      return CH_OTHER;
   endfunction

   function automatic logic [FW-1:0] sat_field(input logic [COUNT_W-1:0] count);
      longint c;
      c = longint'(count);
      return (c > FIELD_MAX) ? FW'(FIELD_MAX) : FW'(c);
   endfunction

   // round half away from zero, clamp to 0..GRADE_TOP
   function automatic logic [GW-1:0] coleman_liau_grade(
      input longint l, input longint w, input longint s);
      longint num;
      longint den;
      longint q;
      num = LETTER_WEIGHT * l - SENTENCE_WEIGHT * s - WORD_WEIGHT * w;
      den = GRADE_SCALE * w;
      if (num >= 0) begin
         q = (2 * num + den) / (2 * den);
      end else begin
         q = -((-2 * num + den) / (2 * den));
      end
      if (q < 0) begin
         q = 0;
      end
      if (q > rgc_pkg::GRADE_TOP) begin
         q = rgc_pkg::GRADE_TOP;
      end
      return GW'(q);
   endfunction

   // count one accepted byte; on the last byte report the text and clear
   function automatic bit tally_byte(input logic [7:0] ch, input bit last,
                                     output grade_report_type rpt);
      rpt = '0;
      case (kind_of(ch))
         CH_LETTER: begin
            if (letters_seen != '1) letters_seen = letters_seen + 1'b1;
         end
         CH_SPACE: begin
            if (words_seen != '1) words_seen = words_seen + 1'b1;
         end
         CH_MARK: begin
            if (sentences_seen != '1) sentences_seen = sentences_seen + 1'b1;
         end
         default: begin
         end
      endcase
      if (!last) begin
         return 1'b0;
      end
      rpt.letters   = sat_field(letters_seen);
      rpt.words     = sat_field(words_seen);
      rpt.sentences = sat_field(sentences_seen);
      rpt.grade     = coleman_liau_grade(longint'(letters_seen), longint'(words_seen),
                                         longint'(sentences_seen));
      letters_seen   = '0;
      words_seen     = COUNT_W'(1);
      sentences_seen = '0;
      return 1'b1;
   endfunction

   function automatic void add_row(input logic [7:0] ch, input int unsigned reps,
                                   input bit last, input bit typed,
                                   input int l, input int w, input int s, input int g);
      text_row_type row;
      row.ch             = ch;
      row.reps           = reps;
      row.last           = last;
      row.typed          = typed;
      row.want.letters   = FW'(l);
      row.want.words     = FW'(w);
      row.want.sentences = FW'(s);
      row.want.grade     = GW'(g);
      directed_rows.push_back(row);
   endfunction

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] ch, input bit last, input bit typed,
                            input grade_report_type want);
      grade_report_type rpt;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = ch;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      if (tally_byte(ch, last, rpt)) begin
         pending_reports.push_back(typed ? want : rpt);
      end
      sent_beats++;
      @(negedge clock);
   endtask

   // mix of letters, spaces, marks and noise, weighted per text to spread grades
   task automatic send_random_text();
      int unsigned      len;
      int unsigned      p_letter;
      int unsigned      p_space;
      int unsigned      p_mark;
      int unsigned      roll;
      logic [7:0]       ch;
      grade_report_type none;
      none     = '0;
      len      = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 50);
      p_letter = $urandom_range(50, 90);
      p_space  = p_letter + $urandom_range(3, 20);
      p_mark   = p_space + $urandom_range(0, 6);
      for (int unsigned i = 0; i < len; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < p_letter) begin
            ch = $urandom_range(0, 1)
               ? 8'($urandom_range(rgc_pkg::CHAR_UPPER_A, rgc_pkg::CHAR_UPPER_Z))
               : 8'($urandom_range(rgc_pkg::CHAR_LOWER_A, rgc_pkg::CHAR_LOWER_Z));
         end else if (roll < p_space) begin
            ch = rgc_pkg::CHAR_SPACE;
         end else if (roll < p_mark) begin
            case ($urandom_range(0, 2))
               0:       ch = rgc_pkg::CHAR_PERIOD;
               1:       ch = rgc_pkg::CHAR_EXCLAIM;
               default: ch = rgc_pkg::CHAR_QUESTION;
            endcase
         end else begin
            ch = 8'($urandom_range(0, 255));
         end
         send_byte(ch, i == len - 1, 1'b0, none);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("result beat with no text pending");
            mismatches++;
         end else begin
            oldest_report = pending_reports.pop_front();
            if (rsp_report.letters !== oldest_report.letters) begin
               $error("letter_count: expected %0d, got %0d",
                      oldest_report.letters, rsp_report.letters);
               mismatches++;
            end
            if (rsp_report.words !== oldest_report.words) begin
               $error("word_count: expected %0d, got %0d",
                      oldest_report.words, rsp_report.words);
               mismatches++;
            end
            if (rsp_report.sentences !== oldest_report.sentences) begin
               $error("sentence_count: expected %0d, got %0d",
                      oldest_report.sentences, rsp_report.sentences);
               mismatches++;
            end
            if (rsp_report.grade !== oldest_report.grade) begin
               $error("grade_level: expected %0d, got %0d",
                      oldest_report.grade, rsp_report.grade);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int unsigned target;
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sent_beats     = 0;
      mismatches     = 0;
      cycle_count    = 0;
      letters_seen   = '0;
      words_seen     = COUNT_W'(1);
      sentences_seen = '0;

      // single-byte texts: results follow straight from the counter reset values
      add_row(rgc_pkg::CHAR_UPPER_A,  1, 1, 1, 1, 1, 0, 0);
      add_row(8'hFF,                  1, 1, 1, 0, 1, 0, 0);
      add_row(8'h00,                  1, 1, 1, 0, 1, 0, 0);
      add_row(rgc_pkg::CHAR_SPACE,    1, 1, 1, 0, 2, 0, 0);
      add_row(rgc_pkg::CHAR_PERIOD,   1, 1, 1, 0, 1, 1, 0);
      add_row(rgc_pkg::CHAR_EXCLAIM,  1, 1, 1, 0, 1, 1, 0);
      add_row(rgc_pkg::CHAR_QUESTION, 1, 1, 1, 0, 1, 1, 0);
      // letter range edges and their neighbors, high bytes ignored
      add_row(rgc_pkg::CHAR_UPPER_Z,             1, 0, 0, 0, 0, 0, 0);
      add_row(rgc_pkg::CHAR_LOWER_A,             1, 0, 0, 0, 0, 0, 0);
      add_row(rgc_pkg::CHAR_LOWER_Z,             1, 0, 0, 0, 0, 0, 0);
      add_row(8'(rgc_pkg::CHAR_UPPER_A - 8'd1),  1, 0, 0, 0, 0, 0, 0);
      add_row(8'(rgc_pkg::CHAR_UPPER_Z + 8'd1),  1, 0, 0, 0, 0, 0, 0);
      add_row(8'(rgc_pkg::CHAR_LOWER_A - 8'd1),  1, 0, 0, 0, 0, 0, 0);
      add_row(8'(rgc_pkg::CHAR_LOWER_Z + 8'd1),  1, 0, 0, 0, 0, 0, 0);
      add_row(8'h80,                             1, 0, 0, 0, 0, 0, 0);
      add_row(rgc_pkg::CHAR_UPPER_A | 8'h80,     1, 0, 0, 0, 0, 0, 0);
      add_row(8'(rgc_pkg::CHAR_LOWER_A + 8'd16), 1, 1, 0, 0, 0, 0, 0);
      // 15 letters, one mark, two words: grade lands exactly on 13.5
      add_row(rgc_pkg::CHAR_LOWER_A, 15, 0, 0, 0, 0, 0, 0);
      add_row(rgc_pkg::CHAR_PERIOD,   1, 0, 0, 0, 0, 0, 0);
      add_row(rgc_pkg::CHAR_SPACE,    1, 1, 0, 0, 0, 0, 0);
      // one long word without marks runs past the top grade
      add_row(rgc_pkg::CHAR_UPPER_A,  6, 1, 1, 6, 1, 0, rgc_pkg::GRADE_TOP);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r]) begin
         for (int unsigned k = 0; k < directed_rows[r].reps; k++) begin
            send_byte(directed_rows[r].ch,
                      directed_rows[r].last && (k == directed_rows[r].reps - 1),
                      directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         target = sent_beats + BEATS_PER_PHASE;
         while (sent_beats < target) begin
            send_random_text();
         end
      end
      req_tvalid = 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
